FILE: design/tile_delta_frame_decoder_macros.svh
// Assertion shorthands, clocked on clock and held off during reset.
`ifndef TILE_DELTA_FRAME_DECODER_MACROS_SVH
`define TILE_DELTA_FRAME_DECODER_MACROS_SVH

// same-cycle implication
`define TDFD_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tdfd assertion failed");

// next-cycle implication
`define TDFD_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tdfd assertion failed");

`endif

FILE: design/tdfd_pkg.sv
`default_nettype none

package tdfd_pkg;

   localparam int FbAddrBits = 19;
   localparam int TileBytes  = 64;
   localparam int MaxTileDim = 64;
   localparam int TileDimCap = (TileBytes < MaxTileDim) ? TileBytes : MaxTileDim;

   localparam int ByteW   = 8;
   localparam int CfgW    = 11;
   localparam int DimW    = 7;
   localparam int PosW    = 6;
   localparam int CountW  = 16;
   localparam int IndexW  = 16;
   localparam int FrameW  = 32;
   localparam int DataW   = 32;

   localparam int DivNumW  = IndexW;
   localparam int DivDenW  = CfgW;
   localparam int DivCntW  = $clog2(DivNumW + 1);

   localparam int RowFullW = DivNumW + DimW + 1;
   localparam int ColFullW = DivDenW + DimW + 1;
   localparam int ProdW    = FbAddrBits + CfgW;

   localparam int RegCount  = 6;
   localparam int RegIndexW = $clog2(RegCount);
   localparam int CsrAddrW  = RegIndexW + 2;

   localparam logic [RegIndexW-1:0] RegLineWidth   = RegIndexW'(0);
   localparam logic [RegIndexW-1:0] RegTilesPerRow = RegIndexW'(1);
   localparam logic [RegIndexW-1:0] RegTileRows    = RegIndexW'(2);
   localparam logic [RegIndexW-1:0] RegTileWidth   = RegIndexW'(3);
   localparam logic [RegIndexW-1:0] RegTileHeight  = RegIndexW'(4);
   localparam logic [RegIndexW-1:0] RegTotalFrames = RegIndexW'(5);

   localparam logic [CfgW-1:0]   LineWidthRst   = CfgW'(320);
   localparam logic [CfgW-1:0]   TilesPerRowRst = CfgW'(40);
   localparam logic [CfgW-1:0]   TileRowsRst    = CfgW'(30);
   localparam logic [DimW-1:0]   TileWidthRst   = DimW'(8);
   localparam logic [DimW-1:0]   TileHeightRst  = DimW'(8);
   localparam logic [FrameW-1:0] TotalFramesRst = FrameW'(0);

   localparam logic [ByteW-1:0]   SkipMore   = ByteW'(255);
   localparam logic [DimW-1:0]    WidthCap   = DimW'(TileDimCap);
   localparam logic [DimW-1:0]    DimMax     = DimW'(MaxTileDim);
   localparam logic [DivNumW-1:0] TileBytesN = DivNumW'(TileBytes);

   typedef struct packed {
      logic [CfgW-1:0]   line_width;
      logic [CfgW-1:0]   tiles_per_row;
      logic [CfgW-1:0]   tile_rows;
      logic [DimW-1:0]   tile_width;
      logic [DimW-1:0]   tile_height;
      logic [FrameW-1:0] total_frames;
   } cfg_type;

   typedef struct packed {
      logic load_cnt_lo;
      logic load_cnt_hi;
      logic add_skip;
      logic take_pixel;
      logic div_lim_start;
      logic latch_lim;
      logic div_tile_start;
      logic calc_pos;
      logic calc_addr;
      logic emit_pixel;
   } cmd_type;

   typedef struct packed {
      logic stream_done;
      logic count_zero;
      logic skip_more;
      logic div_busy;
      logic out_free;
      logic col_end;
      logic row_end;
      logic last_update;
   } status_type;

endpackage

`default_nettype wire

FILE: design/tdfd_if.sv
`default_nettype none

interface tdfd_req_if;
   import tdfd_pkg::*;
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface tdfd_rsp_if;
   import tdfd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  pixel_write;
   logic [FbAddrBits-1:0] fb_address;
   logic [ByteW-1:0]      pixel;
   logic                  out_of_range;
   logic                  frame_done;
   logic [FrameW-1:0]     frame_number;

   modport source (output valid, output pixel_write, output fb_address, output pixel,
                   output out_of_range, output frame_done, output frame_number,
                   input ready);
   modport sink   (input valid, input pixel_write, input fb_address, input pixel,
                   input out_of_range, input frame_done, input frame_number,
                   output ready);
endinterface

`default_nettype wire

FILE: design/tdfd_div.sv
`default_nettype none

module tdfd_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [tdfd_pkg::DivNumW-1:0]   numer,
   input  wire logic [tdfd_pkg::DivDenW-1:0]   denom,
   output logic                                busy,
   output logic [tdfd_pkg::DivNumW-1:0]        quotient,
   output logic [tdfd_pkg::DivDenW-1:0]        remainder
);
   import tdfd_pkg::*;

   logic [DivCntW-1:0] cnt_ff, cnt_in;
   logic [DivNumW-1:0] quo_ff, quo_in;
   logic [DivDenW-1:0] rem_ff, rem_in;
   logic [DivDenW-1:0] den_ff, den_in;
   logic [DivDenW:0]   trial;
   logic [DivDenW:0]   diff;
   logic               fits;

   assign trial = {rem_ff, quo_ff[DivNumW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      if (start) begin
         cnt_in = DivCntW'(DivNumW);
         quo_in = numer;
         rem_in = '0;
         den_in = denom;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - DivCntW'(1);
         if (fits) begin
            rem_in = diff[DivDenW-1:0];
            quo_in = {quo_ff[DivNumW-2:0], 1'b1};
         end else begin
            rem_in = trial[DivDenW-1:0];
            quo_in = {quo_ff[DivNumW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy      = cnt_ff != '0;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

FILE: design/tdfd_ctrl.sv
`default_nettype none

module tdfd_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire tdfd_pkg::status_type   status,
   output tdfd_pkg::cmd_type           cmd
);
   import tdfd_pkg::*;

   localparam int StW = 4;
   localparam logic [StW-1:0] ST_FLAGS     = 4'd0;
   localparam logic [StW-1:0] ST_CNT_LO    = 4'd1;
   localparam logic [StW-1:0] ST_CNT_HI    = 4'd2;
   localparam logic [StW-1:0] ST_SKIP      = 4'd3;
   localparam logic [StW-1:0] ST_PIX       = 4'd4;
   localparam logic [StW-1:0] ST_LIM_GO    = 4'd5;
   localparam logic [StW-1:0] ST_LIM_WAIT  = 4'd6;
   localparam logic [StW-1:0] ST_TILE_GO   = 4'd7;
   localparam logic [StW-1:0] ST_TILE_WAIT = 4'd8;
   localparam logic [StW-1:0] ST_POS       = 4'd9;
   localparam logic [StW-1:0] ST_ADDR      = 4'd10;
   localparam logic [StW-1:0] ST_EMIT      = 4'd11;

   logic [StW-1:0] state_ff, state_in;
   logic           accept;

   assign accept = req_valid && req_ready;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CNT_LO: begin
            req_ready = 1'b1;
            if (accept) begin
               cmd.load_cnt_lo = 1'b1;
               state_in        = ST_CNT_HI;
            end
         end
         ST_CNT_HI: begin
            req_ready = status.out_free;
            if (accept) begin
               cmd.load_cnt_hi = 1'b1;
               state_in        = status.count_zero ? ST_FLAGS : ST_SKIP;
            end
         end
         ST_SKIP: begin
            req_ready = 1'b1;
            if (accept) begin
               cmd.add_skip = 1'b1;
               if (!status.skip_more) begin
                  state_in = ST_PIX;
               end
            end
         end
         ST_PIX: begin
            req_ready = 1'b1;
            if (accept) begin
               cmd.take_pixel = 1'b1;
               state_in       = ST_LIM_GO;
            end
         end
         ST_LIM_GO: begin
            cmd.div_lim_start = 1'b1;
            state_in          = ST_LIM_WAIT;
         end
         ST_LIM_WAIT: begin
            if (!status.div_busy) begin
               cmd.latch_lim = 1'b1;
               state_in      = ST_TILE_GO;
            end
         end
         ST_TILE_GO: begin
            cmd.div_tile_start = 1'b1;
            state_in           = ST_TILE_WAIT;
         end
         ST_TILE_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_POS;
            end
         end
         ST_POS: begin
            cmd.calc_pos = 1'b1;
            state_in     = ST_ADDR;
         end
         ST_ADDR: begin
            cmd.calc_addr = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_pixel = 1'b1;
               if (status.col_end && status.row_end) begin
                  state_in = status.last_update ? ST_FLAGS : ST_SKIP;
               end else begin
                  state_in = ST_PIX;
               end
            end
         end
         default: begin
            req_ready = 1'b1;
            if (accept) begin
               state_in = status.stream_done ? ST_FLAGS : ST_CNT_LO;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FLAGS;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/tdfd_datapath.sv
`default_nettype none

module tdfd_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire tdfd_pkg::cfg_type           cfg,
   input  wire logic [tdfd_pkg::ByteW-1:0]  data_byte,
   input  wire tdfd_pkg::cmd_type           cmd,
   output tdfd_pkg::status_type             status,
   tdfd_rsp_if.source                       rsp_bus
);
   import tdfd_pkg::*;

   logic [ByteW-1:0]      count_low_ff, count_low_in;
   logic [CountW-1:0]     updates_ff, updates_in;
   logic [IndexW-1:0]     tile_index_ff, tile_index_in;
   logic [PosW-1:0]       col_ff, col_in;
   logic [PosW-1:0]       row_ff, row_in;
   logic [FrameW-1:0]     frames_ff, frames_in;
   logic [ByteW-1:0]      pix_ff, pix_in;
   logic [DimW-1:0]       lim_ff, lim_in;
   logic [FbAddrBits-1:0] row_addr_ff, row_addr_in;
   logic [FbAddrBits-1:0] col_addr_ff, col_addr_in;
   logic                  oor_ff, oor_in;
   logic [FbAddrBits-1:0] addr_ff, addr_in;

   logic                  out_valid_ff, out_valid_in;
   logic                  out_write_ff, out_write_in;
   logic [FbAddrBits-1:0] out_addr_ff, out_addr_in;
   logic [ByteW-1:0]      out_pixel_ff, out_pixel_in;
   logic                  out_oor_ff, out_oor_in;
   logic                  out_done_ff, out_done_in;
   logic [FrameW-1:0]     out_frame_ff, out_frame_in;

   logic [DimW-1:0]       w_use;
   logic [DimW-1:0]       h_use;
   logic [CfgW-1:0]       tpr_use;
   logic                  div_start;
   logic                  div_busy;
   logic [DivNumW-1:0]    div_numer;
   logic [DivDenW-1:0]    div_denom;
   logic [DivNumW-1:0]    div_quo;
   logic [DivDenW-1:0]    div_rem;
   logic [RowFullW-1:0]   row_full;
   logic [ColFullW-1:0]   col_full;
   logic [ProdW-1:0]      addr_prod;
   logic [CountW-1:0]     count_word;
   logic [FrameW-1:0]     frames_inc;
   logic                  out_free;
   logic                  tile_end;
   logic                  frame_end;

   always_comb begin
      if (cfg.tile_width == '0) begin
         w_use = DimW'(1);
      end else if (cfg.tile_width > WidthCap) begin
         w_use = WidthCap;
      end else begin
         w_use = cfg.tile_width;
      end
      if (cfg.tile_height == '0) begin
         h_use = DimW'(1);
      end else if (cfg.tile_height > lim_ff) begin
         h_use = lim_ff;
      end else begin
         h_use = cfg.tile_height;
      end
   end

   assign tpr_use = (cfg.tiles_per_row == '0) ? CfgW'(1) : cfg.tiles_per_row;

   assign div_start = cmd.div_lim_start || cmd.div_tile_start;
   assign div_numer = cmd.div_lim_start ? TileBytesN : tile_index_ff;
   assign div_denom = cmd.div_lim_start ? DivDenW'(w_use) : tpr_use;

   tdfd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numer     (div_numer),
      .denom     (div_denom),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      if (div_quo > DivNumW'(DimMax)) begin
         lim_in = DimMax;
      end else if (div_quo == '0) begin
         lim_in = DimW'(1);
      end else begin
         lim_in = div_quo[DimW-1:0];
      end
   end

   assign row_full  = RowFullW'(div_quo) * RowFullW'(h_use) + RowFullW'(row_ff);
   assign col_full  = ColFullW'(div_rem) * ColFullW'(w_use) + ColFullW'(col_ff);
   assign addr_prod = ProdW'(row_addr_ff) * ProdW'(cfg.line_width);

   assign row_addr_in = FbAddrBits'(row_full);
   assign col_addr_in = FbAddrBits'(col_full);
   assign oor_in      = div_quo >= DivNumW'(cfg.tile_rows);
   assign addr_in     = FbAddrBits'(addr_prod) + col_addr_ff;

   assign count_word = {data_byte, count_low_ff};
   assign frames_inc = frames_ff + FrameW'(1);
   assign out_free   = !out_valid_ff || rsp_bus.ready;
   assign tile_end   = status.col_end && status.row_end;
   assign frame_end  = tile_end && status.last_update;

   assign status.stream_done = frames_ff >= cfg.total_frames;
   assign status.count_zero  = count_word == '0;
   assign status.skip_more   = data_byte == SkipMore;
   assign status.div_busy    = div_busy;
   assign status.out_free    = out_free;
   assign status.col_end     = (DimW'(col_ff) + DimW'(1)) >= w_use;
   assign status.row_end     = (DimW'(row_ff) + DimW'(1)) >= h_use;
   assign status.last_update = updates_ff == CountW'(1);

   always_comb begin
      count_low_in  = count_low_ff;
      updates_in    = updates_ff;
      tile_index_in = tile_index_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      frames_in     = frames_ff;
      pix_in        = pix_ff;
      out_valid_in  = out_valid_ff && !rsp_bus.ready;
      out_write_in  = out_write_ff;
      out_addr_in   = out_addr_ff;
      out_pixel_in  = out_pixel_ff;
      out_oor_in    = out_oor_ff;
      out_done_in   = out_done_ff;
      out_frame_in  = out_frame_ff;
      if (cmd.load_cnt_lo) begin
         count_low_in = data_byte;
      end
      if (cmd.load_cnt_hi) begin
         updates_in    = count_word;
         tile_index_in = '0;
         if (status.count_zero) begin
            frames_in    = frames_inc;
            out_valid_in = 1'b1;
            out_write_in = 1'b0;
            out_addr_in  = '0;
            out_pixel_in = '0;
            out_oor_in   = 1'b0;
            out_done_in  = 1'b1;
            out_frame_in = frames_inc;
         end
      end
      if (cmd.add_skip) begin
         tile_index_in = tile_index_ff + IndexW'(data_byte);
         if (!status.skip_more) begin
            col_in = '0;
            row_in = '0;
         end
      end
      if (cmd.take_pixel) begin
         pix_in = data_byte;
      end
      if (cmd.emit_pixel) begin
         out_valid_in = 1'b1;
         out_write_in = !oor_ff;
         out_addr_in  = addr_ff;
         out_pixel_in = pix_ff;
         out_oor_in   = oor_ff;
         out_done_in  = frame_end;
         out_frame_in = frame_end ? frames_inc : frames_ff;
         if (status.col_end) begin
            col_in = '0;
            if (status.row_end) begin
               row_in        = '0;
               tile_index_in = tile_index_ff + IndexW'(1);
               updates_in    = updates_ff - CountW'(1);
               if (status.last_update) begin
                  frames_in = frames_inc;
               end
            end else begin
               row_in = row_ff + PosW'(1);
            end
         end else begin
            col_in = col_ff + PosW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         updates_ff    <= '0;
         tile_index_ff <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         frames_ff     <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         updates_ff    <= updates_in;
         tile_index_ff <= tile_index_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         frames_ff     <= frames_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_low_ff <= count_low_in;
      pix_ff       <= pix_in;
      out_write_ff <= out_write_in;
      out_addr_ff  <= out_addr_in;
      out_pixel_ff <= out_pixel_in;
      out_oor_ff   <= out_oor_in;
      out_done_ff  <= out_done_in;
      out_frame_ff <= out_frame_in;
      if (cmd.latch_lim) begin
         lim_ff <= lim_in;
      end
      if (cmd.calc_pos) begin
         row_addr_ff <= row_addr_in;
         col_addr_ff <= col_addr_in;
         oor_ff      <= oor_in;
      end
      if (cmd.calc_addr) begin
         addr_ff <= addr_in;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.pixel_write  = out_write_ff;
   assign rsp_bus.fb_address   = out_addr_ff;
   assign rsp_bus.pixel        = out_pixel_ff;
   assign rsp_bus.out_of_range = out_oor_ff;
   assign rsp_bus.frame_done   = out_done_ff;
   assign rsp_bus.frame_number = out_frame_ff;

endmodule

`default_nettype wire

FILE: design/tile_delta_frame_decoder.sv
// channel   dir  handshake              transaction carries
// req_bus   in   valid/ready            data_byte
// rsp_bus   out  valid/ready            pixel_write, fb_address, pixel, out_of_range,
//                                       frame_done, frame_number
// csr_*     in   APB write, pready = 1  line_width .. total_frames at byte address 4*i
//
// Flags, count and skip bytes are each taken straight from req_bus, with no divide step.
// A pixel byte holds the block until it is emitted: the 16-step serial divider runs
// twice (tile height limit, then tile column/row), then two multiply stages.
// Synchronous active-high reset; no clearing pass, ready in the first cycle out of reset.
// Results sit in an output register; a stalled rsp_bus holds the next pixel result
// in the emit step and holds the count high byte of every frame at req_bus.
`default_nettype none

module tile_delta_frame_decoder (
   input  wire logic                            clock,
   input  wire logic                            reset,
   tdfd_req_if.sink                             req_bus,
   tdfd_rsp_if.source                           rsp_bus,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [tdfd_pkg::CsrAddrW-1:0]   csr_paddr,
   input  wire logic [tdfd_pkg::DataW-1:0]      csr_pwdata,
   output logic [tdfd_pkg::DataW-1:0]           csr_prdata,
   output logic                                 csr_pready
);
   import tdfd_pkg::*;

   cfg_type              cfg_ff, cfg_in;
   cmd_type              cmd;
   status_type           status;
   logic                 csr_write;
   logic [RegIndexW-1:0] reg_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[CsrAddrW-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_index)
            RegLineWidth:   cfg_in.line_width    = csr_pwdata[CfgW-1:0];
            RegTilesPerRow: cfg_in.tiles_per_row = csr_pwdata[CfgW-1:0];
            RegTileRows:    cfg_in.tile_rows     = csr_pwdata[CfgW-1:0];
            RegTileWidth:   cfg_in.tile_width    = csr_pwdata[DimW-1:0];
            RegTileHeight:  cfg_in.tile_height   = csr_pwdata[DimW-1:0];
            RegTotalFrames: cfg_in.total_frames  = csr_pwdata[FrameW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         RegLineWidth:   csr_prdata = DataW'(cfg_ff.line_width);
         RegTilesPerRow: csr_prdata = DataW'(cfg_ff.tiles_per_row);
         RegTileRows:    csr_prdata = DataW'(cfg_ff.tile_rows);
         RegTileWidth:   csr_prdata = DataW'(cfg_ff.tile_width);
         RegTileHeight:  csr_prdata = DataW'(cfg_ff.tile_height);
         RegTotalFrames: csr_prdata = DataW'(cfg_ff.total_frames);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_width    <= LineWidthRst;
         cfg_ff.tiles_per_row <= TilesPerRowRst;
         cfg_ff.tile_rows     <= TileRowsRst;
         cfg_ff.tile_width    <= TileWidthRst;
         cfg_ff.tile_height   <= TileHeightRst;
         cfg_ff.total_frames  <= TotalFramesRst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tdfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tdfd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .data_byte (req_bus.data_byte),
      .cmd       (cmd),
      .status    (status),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

FILE: design/tdfd_checker.sv
`default_nettype none
`include "tile_delta_frame_decoder_macros.svh"

module tdfd_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic                              rsp_pixel_write,
   input wire logic [tdfd_pkg::FbAddrBits-1:0]   rsp_fb_address,
   input wire logic [tdfd_pkg::ByteW-1:0]        rsp_pixel,
   input wire logic                              rsp_out_of_range,
   input wire logic                              rsp_frame_done,
   input wire logic [tdfd_pkg::FrameW-1:0]       rsp_frame_number
);
   import tdfd_pkg::*;

   logic stalled;
   logic empty_frame;

   assign stalled     = rsp_valid && !rsp_ready;
   assign empty_frame = rsp_valid && rsp_frame_done && !rsp_pixel_write && !rsp_out_of_range;

   `TDFD_ASSERT_NXT(a_rsp_hold, stalled, rsp_valid && $stable(rsp_fb_address) && $stable(rsp_frame_number))
   `TDFD_ASSERT_IMP(a_write_in_range, rsp_valid, !(rsp_pixel_write && rsp_out_of_range))
   `TDFD_ASSERT_IMP(a_empty_frame, empty_frame, rsp_fb_address == '0 && rsp_pixel == '0)
   `TDFD_ASSERT_IMP(a_first_result, $past(reset), !rsp_valid)

endmodule

bind tile_delta_frame_decoder tdfd_checker u_tdfd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_pixel_write  (rsp_bus.pixel_write),
   .rsp_fb_address   (rsp_bus.fb_address),
   .rsp_pixel        (rsp_bus.pixel),
   .rsp_out_of_range (rsp_bus.out_of_range),
   .rsp_frame_done   (rsp_bus.frame_done),
   .rsp_frame_number (rsp_bus.frame_number)
);

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import tdfd_pkg::*;

   typedef enum logic [2:0] {
      PhFlags, PhCountLo, PhCountHi, PhSkip, PhPixel
   } stream_phase_type;

   typedef struct packed {
      logic                  pixel_write;
      logic [FbAddrBits-1:0] fb_address;
      logic [ByteW-1:0]      pixel;
      logic                  out_of_range;
      logic                  frame_done;
      logic [FrameW-1:0]     frame_number;
   } pixel_write_type;

   localparam int SettleCycles = 80;
   localparam int MaxReports   = 10;
   localparam int RandomItems  = 1050;

   logic                clock;
   logic                reset;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CsrAddrW-1:0] csr_paddr;
   logic [DataW-1:0]    csr_pwdata;
   logic [DataW-1:0]    csr_prdata;
   logic                csr_pready;

   tdfd_req_if req_bus ();
   tdfd_rsp_if rsp_bus ();

   tile_delta_frame_decoder u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // decoder state as the stream is accepted
   cfg_type           cfg;
   stream_phase_type  st_phase;
   logic [ByteW-1:0]  count_lo;
   logic [CountW-1:0] updates_left;
   logic [IndexW-1:0] tile_index;
   logic [PosW-1:0]   pix_col;
   logic [PosW-1:0]   pix_row;
   logic [FrameW-1:0] frames_done;

   pixel_write_type pending_writes[$];

   int items_sent;
   int results_seen;
   int oor_seen;
   int mismatches;
   int reg_writes;
   int stall_left;
   bit gaps_on;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic bit decode_byte(input logic [ByteW-1:0] b, output pixel_write_type r);
      int unsigned w;
      int unsigned h;
      int unsigned lim;
      int unsigned tpr;
      int unsigned tx;
      int unsigned ty;
      logic [63:0] addr;
      r = '0;
      decode_byte = 1'b0;
      case (st_phase)
         PhCountLo: begin
            count_lo = b;
            st_phase = PhCountHi;
         end
         PhCountHi: begin
            updates_left = {b, count_lo};
            tile_index = '0;
            if (updates_left == 0) begin
               frames_done++;
               st_phase = PhFlags;
               r.frame_done = 1'b1;
               r.frame_number = frames_done;
               decode_byte = 1'b1;
            end else begin
               st_phase = PhSkip;
            end
         end
         PhSkip: begin
            tile_index = tile_index + b;
            if (b != SkipMore) begin
               pix_col = '0;
               pix_row = '0;
               st_phase = PhPixel;
            end
         end
         PhPixel: begin
            w = cfg.tile_width;
            if (w < 1) w = 1;
            if (w > TileDimCap) w = TileDimCap;
            lim = TileBytes / w;
            if (lim > MaxTileDim) lim = MaxTileDim;
            if (lim < 1) lim = 1;
            h = cfg.tile_height;
            if (h < 1) h = 1;
            if (h > lim) h = lim;
            tpr = (cfg.tiles_per_row == 0) ? 1 : cfg.tiles_per_row;
            tx = tile_index % tpr;
            ty = tile_index / tpr;
            addr = (64'(ty) * h + pix_row) * cfg.line_width + 64'(tx) * w + pix_col;
            r.out_of_range = (ty >= cfg.tile_rows);
            r.pixel_write = !r.out_of_range;
            r.fb_address = FbAddrBits'(addr);
            r.pixel = b;
            if (pix_col + 1 >= w) begin
               pix_col = '0;
               if (pix_row + 1 >= h) begin
                  pix_row = '0;
                  tile_index++;
                  updates_left--;
                  if (updates_left == 0) begin
                     r.frame_done = 1'b1;
                     frames_done++;
                     st_phase = PhFlags;
                  end else begin
                     st_phase = PhSkip;
                  end
               end else begin
                  pix_row++;
               end
            end else begin
               pix_col++;
            end
            r.frame_number = frames_done;
            decode_byte = 1'b1;
         end
         default: begin
            // flags byte; stream closed once all frames are in
            if (frames_done >= cfg.total_frames) begin
               st_phase = PhFlags;
            end else begin
               st_phase = PhCountLo;
            end
         end
      endcase
   endfunction

   task automatic send_byte(input logic [ByteW-1:0] b);
      pixel_write_type r;
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      if (decode_byte(b, r)) pending_writes.push_back(r);
   endtask

   task automatic settle_block();
      req_bus.valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [RegIndexW-1:0] idx, input logic [DataW-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         RegLineWidth:   cfg.line_width = value[CfgW-1:0];
         RegTilesPerRow: cfg.tiles_per_row = value[CfgW-1:0];
         RegTileRows:    cfg.tile_rows = value[CfgW-1:0];
         RegTileWidth:   cfg.tile_width = value[DimW-1:0];
         RegTileHeight:  cfg.tile_height = value[DimW-1:0];
         RegTotalFrames: cfg.total_frames = value[FrameW-1:0];
         default: ;
      endcase
      reg_writes++;
      @(posedge clock);
   endtask

   task automatic set_geometry(input int lw, input int tpr, input int rows, input int tw,
                               input int th);
      settle_block();
      write_reg(RegLineWidth, lw);
      write_reg(RegTilesPerRow, tpr);
      write_reg(RegTileRows, rows);
      write_reg(RegTileWidth, tw);
      write_reg(RegTileHeight, th);
   endtask

   // one frame from the flags byte; returns early when the stream is closed
   task automatic send_frame(input int count, input int max_chain, input int max_skip);
      send_byte(8'($urandom));
      if (st_phase != PhCountLo) return;
      send_byte(8'(count));
      send_byte(8'(count >> ByteW));
      while (st_phase == PhSkip) begin
         repeat ($urandom_range(0, max_chain)) send_byte(SkipMore);
         send_byte(8'($urandom_range(0, max_skip)));
         while (st_phase == PhPixel) send_byte(8'($urandom));
      end
   endtask

   task automatic test_stream_closed();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h01);
      settle_block();
   endtask

   task automatic test_directed_frames();
      write_reg(RegTotalFrames, 32'hFFFF_FFFF);
      write_reg(RegTileWidth, 2);
      write_reg(RegTileHeight, 2);
      // empty frame
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h00);
      // one 2x2 tile after a chained skip
      send_byte(8'h00);
      send_byte(8'h01);
      send_byte(8'h00);
      send_byte(SkipMore);
      send_byte(SkipMore);
      send_byte(8'h03);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hAA);
      send_byte(8'h55);
   endtask

   task automatic test_geometry_extremes();
      // 1x1 tiles, zero tiles per row, every tile past the last row
      set_geometry(1, 0, 0, 0, 0);
      send_frame(3, 1, 254);
      // width clamps to 64, height to 1
      set_geometry(2047, 2047, 2047, 127, 127);
      send_frame(2, 0, 3);
      // tall tiles, one per row: address wraps
      set_geometry(2047, 1, 2047, 1, 127);
      send_frame(2, 2, 254);
      // height clamps so the tile stays within 64 bytes
      set_geometry(320, 40, 30, 8, 20);
      send_frame(1, 0, 0);
      // mix of tiles inside and past the frame
      set_geometry(100, 3, 2, 2, 3);
      send_frame(5, 0, 4);
   endtask

   task automatic test_mid_tile_change();
      set_geometry(64, 8, 8, 4, 4);
      send_byte(8'h00);
      send_byte(8'h01);
      send_byte(8'h00);
      send_byte(8'h05);
      repeat (6) send_byte(8'($urandom));
      settle_block();
      // column already past the new width
      write_reg(RegTileWidth, 2);
      write_reg(RegTileHeight, 1);
      while (st_phase == PhPixel) send_byte(8'($urandom));
      settle_block();
   endtask

   task automatic test_stream_end();
      set_geometry(64, 8, 8, 2, 2);
      write_reg(RegTotalFrames, frames_done + 2);
      repeat (4) send_frame($urandom_range(0, 1), 0, 3);
      settle_block();
      write_reg(RegTotalFrames, 32'hFFFF_FFFF);
   endtask

   task automatic test_long_frame();
      set_geometry(256, 16, 16, 1, 1);
      send_frame(16'h0100, 0, 2);
   endtask

   task automatic test_random();
      int target;
      int lw;
      int tw;
      int th;
      target = items_sent + RandomItems;
      while (items_sent < target) begin
         if ($urandom_range(0, 2) == 0) begin
            lw = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2047) : $urandom_range(1, 400);
            tw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
            th = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
            set_geometry(lw,
                         ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                                     : $urandom_range(1, 50),
                         ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                                     : $urandom_range(1, 40),
                         tw, th);
         end
         if (items_sent > target - RandomItems / 6) gaps_on = 1'b0;
         if ($urandom_range(0, 9) == 0) settle_block();
         send_frame(($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3),
                    ($urandom_range(0, 5) == 0) ? 2 : 0,
                    ($urandom_range(0, 3) == 0) ? 254 : 3);
      end
   endtask

   always @(posedge clock) begin
      pixel_write_type got;
      pixel_write_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.pixel_write, rsp_bus.fb_address, rsp_bus.pixel,
                   rsp_bus.out_of_range, rsp_bus.frame_done, rsp_bus.frame_number};
            results_seen++;
            if (pending_writes.size() == 0) begin
               mismatches++;
               if (mismatches <= MaxReports) begin
                  $display("unexpected transaction: wr=%b addr=%h pix=%h oor=%b done=%b frame=%0d",
                           got.pixel_write, got.fb_address, got.pixel, got.out_of_range,
                           got.frame_done, got.frame_number);
               end
            end else begin
               want = pending_writes.pop_front();
               if (want.out_of_range) oor_seen++;
               if (got.pixel_write !== want.pixel_write || got.fb_address !== want.fb_address
                   || got.pixel !== want.pixel || got.out_of_range !== want.out_of_range
                   || got.frame_done !== want.frame_done
                   || got.frame_number !== want.frame_number) begin
                  mismatches++;
                  if (mismatches <= MaxReports) begin
                     $display("transaction %0d exp: wr=%b addr=%h pix=%h oor=%b done=%b frame=%0d",
                              results_seen, want.pixel_write, want.fb_address, want.pixel,
                              want.out_of_range, want.frame_done, want.frame_number);
                     $display("transaction %0d got: wr=%b addr=%h pix=%h oor=%b done=%b frame=%0d",
                              results_seen, got.pixel_write, got.fb_address, got.pixel,
                              got.out_of_range, got.frame_done, got.frame_number);
                  end
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      rsp_bus.ready = 1'b0;
      gaps_on = 1'b1;
      items_sent = 0;
      results_seen = 0;
      oor_seen = 0;
      mismatches = 0;
      reg_writes = 0;
      cfg = '{line_width: LineWidthRst, tiles_per_row: TilesPerRowRst,
              tile_rows: TileRowsRst, tile_width: TileWidthRst,
              tile_height: TileHeightRst, total_frames: TotalFramesRst};
      st_phase = PhFlags;
      count_lo = '0;
      updates_left = '0;
      tile_index = '0;
      pix_col = '0;
      pix_row = '0;
      frames_done = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_stream_closed();
      test_directed_frames();
      test_geometry_extremes();
      test_mid_tile_change();
      test_stream_end();
      test_long_frame();
      test_random();
      settle_block();

      $display("sent %0d stream bytes over %0d register writes, %0d frames decoded",
               items_sent, reg_writes, frames_done);
      $display("checked %0d pixel transactions, %0d of them past the last tile row",
               results_seen, oor_seen);
      if (mismatches == 0 && pending_writes.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("timeout with %0d transactions outstanding", pending_writes.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
